[hdl/mwsm_pkg.sv]
`timescale 1ns / 1ps

package mwsm_pkg;

  localparam int FRAC_BITS_DEF = 16;

  localparam int RECIP_W = 24;
  localparam int LEN_W   = 20;
  localparam int LIMIT_W = 22;
  localparam int ID_W    = 16;
  localparam int VEL_W   = 32;
  localparam int SPEED_W = 23;

  localparam int SAT_W   = 38;
  localparam int NORM_W  = 40;
  localparam int Q_W     = LIMIT_W;
  localparam int MUL_A_W = NORM_W;
  localparam int MUL_B_W = RECIP_W;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int WHEELS  = 4;

  localparam int S_DATA_W = 104;
  localparam int S_USER_W = 3;
  localparam int M_DATA_W = 160;
  localparam int ADDR_W   = 5;
  localparam int APB_W    = 32;

  localparam logic [SAT_W-1:0] SAT_MAX = '1;

  localparam logic [RECIP_W-1:0] RECIP_RST = 24'd873813;
  localparam logic [LEN_W-1:0]   LENGTH_RST = 20'd30802;
  localparam logic [LEN_W-1:0]   WIDTH_RST = 20'd26870;
  localparam logic [LIMIT_W-1:0] LIMIT_RST = 22'd3276800;

  typedef enum logic [2:0] {
    REG_RECIP  = 3'd0,
    REG_LENGTH = 3'd1,
    REG_WIDTH  = 3'd2,
    REG_LIMIT  = 3'd3,
    REG_ID_FL  = 3'd4,
    REG_ID_FR  = 3'd5,
    REG_ID_RL  = 3'd6,
    REG_ID_RR  = 3'd7
  } reg_idx_t;

  typedef enum logic [1:0] {
    CMD_VEL  = 2'd0,
    CMD_STOP = 2'd1,
    CMD_TICK = 2'd2,
    CMD_NONE = 2'd3
  } cmd_t;

endpackage

[hdl/mecanum_wheel_speed_mixer_top.sv]
`timescale 1ns / 1ps

// Channel   Direction  Handshake          Payload
// s_*       in         s_tvalid/s_tready  s_tdata, s_tuser (command requests)
// m_*       out        m_tvalid/m_tready  m_tdata (four wheel speeds and ids)
// APB       in         psel/penable       paddr, pwdata, prdata (registers)
//
// A request that yields a result passes the rotation term, the wheel sums and
// a product per wheel; if desaturation is needed, the values are shifted right
// a bit at a time until the largest fits in 40 bits, then a serial divider
// scales each wheel by limit/max. One shared 40x24 multiplier serves all of
// these products. Reset is synchronous and active high. s_tready is low while
// a request is in work; a finished result waits in the output register.

module mecanum_wheel_speed_mixer_top #(
  parameter int FRAC_BITS = mwsm_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // vel_fwd, vel_side, yaw_rate, stop_request
  input  logic [mwsm_pkg::S_DATA_W-1:0] s_tdata,
  // cmd, cmd_invalid
  input  logic [mwsm_pkg::S_USER_W-1:0] s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // speed_front_left, speed_front_right, speed_rear_left, speed_rear_right,
  // out_id_fl, out_id_fr, out_id_rl, out_id_rr
  output logic [mwsm_pkg::M_DATA_W-1:0] m_tdata,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mwsm_pkg::ADDR_W-1:0]   paddr,
  input  logic [mwsm_pkg::APB_W-1:0]    pwdata,
  output logic [mwsm_pkg::APB_W-1:0]    prdata,
  output logic                          pready
);

  import mwsm_pkg::*;

  localparam int ROT_W = 54 - FRAC_BITS;
  localparam int SUM_W = ((ROT_W > VEL_W) ? ROT_W : VEL_W) + 3;
  localparam int ABS_W = (SUM_W > SAT_W) ? SUM_W : SAT_W;
  localparam int M_W   = 65 - FRAC_BITS;
  localparam int CNT_W = $clog2(Q_W);
  localparam int IDX_W = $clog2(WHEELS);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ROT_MUL,
    ST_SUMS,
    ST_W_MUL,
    ST_W_RND,
    ST_CHECK,
    ST_NORM,
    ST_S_MUL,
    ST_S_INIT,
    ST_S_DIV,
    ST_S_STORE,
    ST_FINISH
  } state_t;

  state_t state;

  logic [RECIP_W-1:0] recip;
  logic [LEN_W-1:0]   body_length;
  logic [LEN_W-1:0]   body_width;
  logic [LIMIT_W-1:0] limit;
  logic [ID_W-1:0]    ids [WHEELS];

  logic [VEL_W-1:0] held_fwd;
  logic [VEL_W-1:0] held_side;
  logic [VEL_W-1:0] held_yaw;
  logic             stop_active;

  logic              y_neg;
  logic [PROD_W-1:0] prod;
  logic [SAT_W-1:0]  mag [WHEELS];
  logic              neg [WHEELS];
  logic [M_W-1:0]    m [WHEELS];
  logic [M_W-1:0]    maxm;
  logic [Q_W-1:0]    q [WHEELS];
  logic              scaled;
  logic [IDX_W-1:0]  idx;
  logic [CNT_W-1:0]  cnt;
  logic [NORM_W-1:0] div_rem;
  logic [Q_W-1:0]    div_num;

  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [PROD_W-1:0]  prod_comb;

  logic               accept;
  cmd_t               cmd_in;
  logic               cfg_write;
  logic [VEL_W-1:0]   y_eff;
  logic [VEL_W-1:0]   y_abs;

  logic [54:0]             rot_round;
  logic [ROT_W-1:0]        rot_mag;
  logic signed [SUM_W-1:0] rot_s;
  logic signed [SUM_W-1:0] f_s;
  logic signed [SUM_W-1:0] sd_s;
  logic signed [SUM_W-1:0] sum_s [WHEELS];
  logic [ABS_W-1:0]        sum_abs [WHEELS];
  logic [SAT_W-1:0]        mag_next [WHEELS];

  logic [PROD_W-1:0] w_round;
  logic [M_W-1:0]    m_next;

  logic [NORM_W:0]   div_t;
  logic [NORM_W:0]   div_diff;
  logic              div_ge;

  logic [M_W-1:0]     m_signed [WHEELS];
  logic [SPEED_W-1:0] q_signed [WHEELS];
  logic [SPEED_W-1:0] speed [WHEELS];

  assign pready    = 1'b1;
  assign s_tready  = (state == ST_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign cmd_in    = cmd_t'(s_tuser[1:0]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    unique case (reg_idx_t'(paddr[4:2]))
      REG_RECIP:  prdata = APB_W'(recip);
      REG_LENGTH: prdata = APB_W'(body_length);
      REG_WIDTH:  prdata = APB_W'(body_width);
      REG_LIMIT:  prdata = APB_W'(limit);
      REG_ID_FL:  prdata = APB_W'(ids[0]);
      REG_ID_FR:  prdata = APB_W'(ids[1]);
      REG_ID_RL:  prdata = APB_W'(ids[2]);
      REG_ID_RR:  prdata = APB_W'(ids[3]);
      default:    prdata = '0;
    endcase
  end

  assign y_eff = stop_active ? '0 : held_yaw;
  assign y_abs = y_eff[VEL_W-1] ? (~y_eff + 1'b1) : y_eff;

  always_comb begin
    case (state)
      ST_ROT_MUL: begin
        mul_a = MUL_A_W'(y_abs);
        mul_b = MUL_B_W'({1'b0, body_length} + {1'b0, body_width});
      end
      ST_W_MUL: begin
        mul_a = MUL_A_W'(mag[idx]);
        mul_b = recip;
      end
      ST_S_MUL: begin
        mul_a = m[idx][NORM_W-1:0];
        mul_b = MUL_B_W'(limit);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_comb = PROD_W'(mul_a) * PROD_W'(mul_b);

  assign rot_round = {1'b0, prod[53:0]} + (55'(1) << FRAC_BITS);
  assign rot_mag   = rot_round[54:FRAC_BITS+1];
  assign rot_s     = y_neg ? -$signed(SUM_W'(rot_mag)) : $signed(SUM_W'(rot_mag));
  assign f_s       = stop_active ? '0 : SUM_W'($signed(held_fwd));
  assign sd_s      = stop_active ? '0 : SUM_W'($signed(held_side));

  always_comb begin
    for (int i = 0; i < WHEELS; i++) begin
      sum_s[i] = rot_s + (((i % 2) == 1) ? f_s : -f_s) + ((i >= 2) ? sd_s : -sd_s);
      sum_abs[i] = ABS_W'(sum_s[i][SUM_W-1] ? -sum_s[i] : sum_s[i]);
      mag_next[i] = (sum_abs[i] > ABS_W'(SAT_MAX)) ? SAT_MAX : sum_abs[i][SAT_W-1:0];
    end
  end

  assign w_round = prod + (PROD_W'(1) << (FRAC_BITS - 1));
  assign m_next  = M_W'(w_round >> FRAC_BITS);

  assign div_t    = {div_rem, div_num[Q_W-1]};
  assign div_ge   = div_t >= {1'b0, maxm[NORM_W-1:0]};
  assign div_diff = div_t - {1'b0, maxm[NORM_W-1:0]};

  always_comb begin
    for (int i = 0; i < WHEELS; i++) begin
      m_signed[i] = neg[i] ? (~m[i] + 1'b1) : m[i];
      q_signed[i] = neg[i] ? (~SPEED_W'(q[i]) + 1'b1) : SPEED_W'(q[i]);
      speed[i]    = scaled ? q_signed[i] : m_signed[i][SPEED_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      recip       <= RECIP_RST;
      body_length <= LENGTH_RST;
      body_width  <= WIDTH_RST;
      limit       <= LIMIT_RST;
      ids[0]      <= 16'd0;
      ids[1]      <= 16'd1;
      ids[2]      <= 16'd2;
      ids[3]      <= 16'd3;
      held_fwd    <= '0;
      held_side   <= '0;
      held_yaw    <= '0;
      stop_active <= 1'b0;
      m_tvalid    <= 1'b0;
      idx         <= '0;
      cnt         <= '0;
      scaled      <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (reg_idx_t'(paddr[4:2]))
          REG_RECIP:  recip       <= pwdata[RECIP_W-1:0];
          REG_LENGTH: body_length <= pwdata[LEN_W-1:0];
          REG_WIDTH:  body_width  <= pwdata[LEN_W-1:0];
          REG_LIMIT:  limit       <= pwdata[LIMIT_W-1:0];
          REG_ID_FL:  ids[0]      <= pwdata[ID_W-1:0];
          REG_ID_FR:  ids[1]      <= pwdata[ID_W-1:0];
          REG_ID_RL:  ids[2]      <= pwdata[ID_W-1:0];
          REG_ID_RR:  ids[3]      <= pwdata[ID_W-1:0];
          default: ;
        endcase
      end

      if (m_tvalid && m_tready && (state != ST_FINISH)) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            unique case (cmd_in)
              CMD_VEL: begin
                if (s_tuser[2]) begin
                  held_fwd  <= '0;
                  held_side <= '0;
                  held_yaw  <= '0;
                end else begin
                  held_fwd  <= s_tdata[31:0];
                  held_side <= s_tdata[63:32];
                  held_yaw  <= s_tdata[95:64];
                end
                state <= ST_ROT_MUL;
              end
              CMD_STOP: begin
                stop_active <= s_tdata[96];
                state       <= ST_ROT_MUL;
              end
              CMD_TICK: begin
                if (stop_active) begin
                  state <= ST_ROT_MUL;
                end
              end
              default: ;
            endcase
          end
        end
        ST_ROT_MUL: begin
          prod  <= prod_comb;
          y_neg <= y_eff[VEL_W-1];
          state <= ST_SUMS;
        end
        ST_SUMS: begin
          for (int i = 0; i < WHEELS; i++) begin
            mag[i] <= mag_next[i];
            neg[i] <= sum_s[i][SUM_W-1];
          end
          maxm  <= '0;
          idx   <= '0;
          state <= ST_W_MUL;
        end
        ST_W_MUL: begin
          prod  <= prod_comb;
          state <= ST_W_RND;
        end
        ST_W_RND: begin
          m[idx] <= m_next;
          if (m_next > maxm) begin
            maxm <= m_next;
          end
          idx <= idx + 1'b1;
          if (idx == IDX_W'(WHEELS - 1)) begin
            state <= ST_CHECK;
          end else begin
            state <= ST_W_MUL;
          end
        end
        ST_CHECK: begin
          if (maxm > M_W'(limit)) begin
            scaled <= 1'b1;
            state  <= ST_NORM;
          end else begin
            scaled <= 1'b0;
            state  <= ST_FINISH;
          end
        end
        ST_NORM: begin
          if (|maxm[M_W-1:NORM_W]) begin
            maxm <= maxm >> 1;
            for (int i = 0; i < WHEELS; i++) begin
              m[i] <= m[i] >> 1;
            end
          end else begin
            idx   <= '0;
            state <= ST_S_MUL;
          end
        end
        ST_S_MUL: begin
          prod  <= prod_comb;
          state <= ST_S_INIT;
        end
        ST_S_INIT: begin
          div_rem <= prod[Q_W+NORM_W-1:Q_W];
          div_num <= prod[Q_W-1:0];
          cnt     <= '0;
          state   <= ST_S_DIV;
        end
        ST_S_DIV: begin
          div_rem <= div_ge ? div_diff[NORM_W-1:0] : div_t[NORM_W-1:0];
          div_num <= {div_num[Q_W-2:0], div_ge};
          cnt     <= cnt + 1'b1;
          if (cnt == CNT_W'(Q_W - 1)) begin
            state <= ST_S_STORE;
          end
        end
        ST_S_STORE: begin
          q[idx] <= div_num;
          idx    <= idx + 1'b1;
          if (idx == IDX_W'(WHEELS - 1)) begin
            state <= ST_FINISH;
          end else begin
            state <= ST_S_MUL;
          end
        end
        ST_FINISH: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {4'b0, ids[3], ids[2], ids[1], ids[0],
                         speed[3], speed[2], speed[1], speed[0]};
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

[verif/tb_mecanum_wheel_speed_mixer_top.sv]
`timescale 1ns / 1ps

module tb_mecanum_wheel_speed_mixer_top;
  import mwsm_pkg::*;

  localparam int FB = FRAC_BITS_DEF;
  localparam int SETTLE_CYCLES = 200;
  localparam int DRAIN_LIMIT = 20000;
  localparam int REPORT_MAX = 10;
  localparam int RANDOM_PER_PROFILE = 90;
  localparam int PROFILES = 7;
  localparam logic [63:0] SUM_CAP = (64'd1 << SAT_W) - 64'd1;
  localparam logic [63:0] NORM_CEIL = 64'd1 << NORM_W;
  localparam logic [31:0] ONE = 32'h0001_0000;
  localparam logic [M_DATA_W-1:0] ZERO_SPEEDS_RESET_IDS =
    {4'b0, 16'd3, 16'd2, 16'd1, 16'd0, 92'b0};

  typedef enum int {CHK_MODEL, CHK_NONE, CHK_ZERO} row_check_t;

  typedef struct {
    cmd_t        op;
    logic [31:0] fwd;
    logic [31:0] side;
    logic [31:0] yaw;
    logic        invalid;
    logic        stop_req;
    row_check_t  chk;
  } mixer_request_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  // vel_fwd, vel_side, yaw_rate, stop_request
  logic [S_DATA_W-1:0] s_tdata = '0;
  // cmd, cmd_invalid
  logic [S_USER_W-1:0] s_tuser = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  // speed_front_left, speed_front_right, speed_rear_left, speed_rear_right,
  // out_id_fl, out_id_fr, out_id_rl, out_id_rr
  logic [M_DATA_W-1:0] m_tdata;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ADDR_W-1:0]   paddr = '0;
  logic [APB_W-1:0]    pwdata = '0;
  logic [APB_W-1:0]    prdata;
  logic                pready;

  logic [RECIP_W-1:0] cfg_recip = RECIP_RST;
  logic [LEN_W-1:0]   cfg_length = LENGTH_RST;
  logic [LEN_W-1:0]   cfg_width = WIDTH_RST;
  logic [LIMIT_W-1:0] cfg_limit = LIMIT_RST;
  logic [ID_W-1:0]    cfg_id [WHEELS] = '{16'd0, 16'd1, 16'd2, 16'd3};

  logic signed [31:0] held_fwd = '0;
  logic signed [31:0] held_side = '0;
  logic signed [31:0] held_yaw = '0;
  logic               stop_latched = 1'b0;

  logic [M_DATA_W-1:0] wheel_speed_backlog [$];
  int                  fault_count = 0;
  int                  results_seen = 0;
  int                  burst_left = 0;
  bit                  bursty = 1'b1;
  string               wheel_name [WHEELS] = '{"FL", "FR", "RL", "RR"};

  mecanum_wheel_speed_mixer_top #(.FRAC_BITS(FB)) u_top (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic note_fault(input string what);
    fault_count++;
    if (fault_count <= REPORT_MAX) begin
      $display("%0t: %s", $time, what);
    end
  endtask

  function automatic logic [63:0] magnitude(input longint v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic [M_DATA_W-1:0] mix_wheels();
    longint              f;
    longint              sd;
    longint              y;
    longint              rot;
    longint              sum [WHEELS];
    logic [63:0]         rm;
    logic [63:0]         sm;
    logic [63:0]         maxm;
    logic [63:0]         m [WHEELS];
    logic [63:0]         sp;
    int                  k;
    logic [M_DATA_W-1:0] r;
    f = 0;
    sd = 0;
    y = 0;
    maxm = '0;
    r = '0;
    if (!stop_latched) begin
      f = held_fwd;
      sd = held_side;
      y = held_yaw;
    end
    rm = ((64'(cfg_length) + 64'(cfg_width)) * magnitude(y) + (64'd1 << FB)) >> (FB + 1);
    rot = (y < 0) ? -longint'(rm) : longint'(rm);
    sum[0] = -(f + sd - rot);
    sum[1] = f - sd + rot;
    sum[2] = -(f - sd - rot);
    sum[3] = f + sd + rot;
    for (int i = 0; i < WHEELS; i++) begin
      sm = magnitude(sum[i]);
      if (sm > SUM_CAP) begin
        sm = SUM_CAP;
      end
      m[i] = (sm * 64'(cfg_recip) + (64'd1 << (FB - 1))) >> FB;
      if (m[i] > maxm) begin
        maxm = m[i];
      end
    end
    if (maxm > 64'(cfg_limit)) begin
      k = 0;
      while ((maxm >> k) >= NORM_CEIL) begin
        k++;
      end
      maxm = maxm >> k;
      for (int i = 0; i < WHEELS; i++) begin
        m[i] = ((m[i] >> k) * 64'(cfg_limit)) / maxm;
      end
    end
    for (int i = 0; i < WHEELS; i++) begin
      sp = (sum[i] < 0) ? 64'd0 - m[i] : m[i];
      r[i*SPEED_W +: SPEED_W] = sp[SPEED_W-1:0];
      r[WHEELS*SPEED_W + i*ID_W +: ID_W] = cfg_id[i];
    end
    return r;
  endfunction

  function automatic bit advance_mixer(input mixer_request_t rq,
                                       output logic [M_DATA_W-1:0] res);
    res = '0;
    case (rq.op)
      CMD_VEL: begin
        if (rq.invalid) begin
          held_fwd = '0;
          held_side = '0;
          held_yaw = '0;
        end else begin
          held_fwd = rq.fwd;
          held_side = rq.side;
          held_yaw = rq.yaw;
        end
      end
      CMD_STOP: stop_latched = rq.stop_req;
      CMD_TICK: begin
        if (!stop_latched) begin
          return 1'b0;
        end
      end
      default: return 1'b0;
    endcase
    res = mix_wheels();
    return 1'b1;
  endfunction

  function automatic logic [31:0] field_mask(input reg_idx_t r);
    case (r)
      REG_RECIP: return 32'((64'd1 << RECIP_W) - 1);
      REG_LENGTH, REG_WIDTH: return 32'((64'd1 << LEN_W) - 1);
      REG_LIMIT: return 32'((64'd1 << LIMIT_W) - 1);
      default: return 32'((64'd1 << ID_W) - 1);
    endcase
  endfunction

  task automatic write_register(input reg_idx_t r, input logic [31:0] v);
    logic [31:0] keep;
    keep = v & field_mask(r);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = ADDR_W'({r, 2'b00});
    pwdata = v;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    case (r)
      REG_RECIP: cfg_recip = keep[RECIP_W-1:0];
      REG_LENGTH: cfg_length = keep[LEN_W-1:0];
      REG_WIDTH: cfg_width = keep[LEN_W-1:0];
      REG_LIMIT: cfg_limit = keep[LIMIT_W-1:0];
      REG_ID_FL: cfg_id[0] = keep[ID_W-1:0];
      REG_ID_FR: cfg_id[1] = keep[ID_W-1:0];
      REG_ID_RL: cfg_id[2] = keep[ID_W-1:0];
      default: cfg_id[3] = keep[ID_W-1:0];
    endcase
    @(negedge clk);
    pwrite = 1'b0;
    penable = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== keep) begin
      note_fault($sformatf("register %s read back: expected %h, actual %h",
                           r.name(), keep, prdata));
    end
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  task automatic load_profile(input int profile);
    logic [31:0] vals [8];
    case (profile)
      0: vals = '{32'd1, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0};
      1: vals = '{32'hFF_FFFF, 32'hF_FFFF, 32'hF_FFFF, 32'h3F_FFFF,
                  32'hFFFF, 32'hFFFF, 32'hFFFF, 32'hFFFF};
      2: vals = '{32'd873813, 32'd30802, 32'd26870, 32'd3276800,
                  $urandom(), $urandom(), $urandom(), $urandom()};
      3: vals = '{32'd0, 32'hF_FFFF, 32'd0, 32'd1,
                  $urandom(), $urandom(), $urandom(), $urandom()};
      default: begin
        vals = '{$urandom_range(1 << 16, 1 << 21), $urandom_range(0, 1 << 17),
                 $urandom_range(0, 1 << 17), $urandom_range(1, 3276800),
                 $urandom(), $urandom(), $urandom(), $urandom()};
        for (int i = 0; i < 8; i++) begin
          vals[i] = vals[i] | ($urandom() & ~field_mask(reg_idx_t'(i)));
        end
      end
    endcase
    for (int i = 0; i < 8; i++) begin
      write_register(reg_idx_t'(i), vals[i]);
    end
  endtask

  function automatic logic [31:0] random_velocity();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'hFFFF_FFFF;
          3: return 32'h0000_0001;
          default: return '0;
        endcase
      end
      1, 2: return $urandom();
      default: return 32'(int'($urandom_range(0, 1 << 19)) - (1 << 18));
    endcase
  endfunction

  function automatic mixer_request_t random_request();
    mixer_request_t rq;
    int             pick;
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      rq.op = CMD_VEL;
    end else if (pick < 65) begin
      rq.op = CMD_STOP;
    end else if (pick < 95) begin
      rq.op = CMD_TICK;
    end else begin
      rq.op = CMD_NONE;
    end
    rq.fwd = random_velocity();
    rq.side = random_velocity();
    rq.yaw = random_velocity();
    rq.invalid = ($urandom_range(0, 6) == 0);
    rq.stop_req = 1'($urandom_range(0, 1));
    rq.chk = CHK_MODEL;
    return rq;
  endfunction

  task automatic pace_sender();
    if (bursty) begin
      if (burst_left == 0) begin
        repeat ($urandom_range(1, 12)) @(negedge clk) s_tvalid = 1'b0;
        burst_left = $urandom_range(1, 24);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic offer_request(input mixer_request_t rq);
    logic [M_DATA_W-1:0] res;
    bit                  has;
    @(negedge clk);
    s_tvalid = 1'b1;
    s_tdata = {7'b0, rq.stop_req, rq.yaw, rq.side, rq.fwd};
    s_tuser = {rq.invalid, rq.op};
    do @(posedge clk); while (!s_tready);
    has = advance_mixer(rq, res);
    case (rq.chk)
      CHK_MODEL: begin
        if (has) begin
          wheel_speed_backlog = {wheel_speed_backlog, res};
        end
      end
      CHK_ZERO: wheel_speed_backlog = {wheel_speed_backlog, ZERO_SPEEDS_RESET_IDS};
      default: ;
    endcase
  endtask

  task automatic drain_results();
    @(negedge clk);
    s_tvalid = 1'b0;
    for (int w = 0; w < DRAIN_LIMIT && wheel_speed_backlog.size() != 0; w++) begin
      @(posedge clk);
    end
    if (wheel_speed_backlog.size() != 0) begin
      note_fault($sformatf("%0d results never arrived", wheel_speed_backlog.size()));
      fault_count += wheel_speed_backlog.size() - 1;
      wheel_speed_backlog.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin : check_results
    logic [M_DATA_W-1:0] want;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (wheel_speed_backlog.size() == 0) begin
        note_fault($sformatf("unexpected result %h", m_tdata));
      end else begin
        want = wheel_speed_backlog.pop_front();
        for (int w = 0; w < WHEELS; w++) begin
          if (m_tdata[w*SPEED_W +: SPEED_W] !== want[w*SPEED_W +: SPEED_W]) begin
            note_fault($sformatf("speed %s: expected %h, actual %h", wheel_name[w],
                                 want[w*SPEED_W +: SPEED_W], m_tdata[w*SPEED_W +: SPEED_W]));
          end
          if (m_tdata[WHEELS*SPEED_W + w*ID_W +: ID_W] !==
              want[WHEELS*SPEED_W + w*ID_W +: ID_W]) begin
            note_fault($sformatf("id %s: expected %h, actual %h", wheel_name[w],
                                 want[WHEELS*SPEED_W + w*ID_W +: ID_W],
                                 m_tdata[WHEELS*SPEED_W + w*ID_W +: ID_W]));
          end
        end
      end
    end
  end

  // The receiver has its own rhythm, and once holds off long enough for the
  // block to fill up and stall the sender.
  initial begin
    int mode;
    int span;
    int beat;
    bit held_off;
    beat = 0;
    held_off = 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 200);
      if (!held_off && results_seen >= 150) begin
        held_off = 1'b1;
        repeat (400) @(negedge clk) m_tready = 1'b0;
      end
      repeat (span) begin
        @(negedge clk);
        beat++;
        case (mode)
          0: m_tready = 1'b1;
          1: m_tready = 1'($urandom_range(0, 1));
          2: m_tready = ($urandom_range(0, 3) == 0);
          default: m_tready = ((beat % 5) < 3);
        endcase
      end
    end
  end

  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    mixer_request_t directed [20];
    directed = '{
      '{CMD_VEL, 32'h0, 32'h0, 32'h0, 1'b0, 1'b0, CHK_ZERO},
      '{CMD_TICK, ONE, ONE, ONE, 1'b1, 1'b1, CHK_NONE},
      '{CMD_NONE, ONE, ONE, ONE, 1'b0, 1'b1, CHK_NONE},
      '{CMD_VEL, ONE, 32'h0, 32'h0, 1'b0, 1'b0, CHK_MODEL},
      '{CMD_VEL, 32'h0, ONE, 32'h0, 1'b0, 1'b0, CHK_MODEL},
      '{CMD_VEL, 32'h0, 32'h0, ONE, 1'b0, 1'b0, CHK_MODEL},
      '{CMD_VEL, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 1'b0, CHK_MODEL},
      '{CMD_VEL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0, 1'b0, CHK_MODEL},
      '{CMD_VEL, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 1'b0, CHK_MODEL},
      '{CMD_VEL, 32'hFFFF_FFFF, 32'h1, 32'hFFFF_FFFF, 1'b0, 1'b0, CHK_MODEL},
      '{CMD_VEL, 32'h0, 32'h0, 32'h1, 1'b0, 1'b0, CHK_MODEL},
      '{CMD_VEL, 32'h0002_8000, 32'hFFFE_0000, 32'h0000_C000, 1'b1, 1'b0, CHK_ZERO},
      '{CMD_VEL, 32'h0002_8000, 32'hFFFE_0000, 32'h0000_C000, 1'b0, 1'b1, CHK_MODEL},
      '{CMD_STOP, ONE, ONE, ONE, 1'b1, 1'b1, CHK_ZERO},
      '{CMD_TICK, 32'h0, 32'h0, 32'h0, 1'b0, 1'b0, CHK_ZERO},
      '{CMD_VEL, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_4000, 1'b0, 1'b0, CHK_ZERO},
      '{CMD_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, CHK_NONE},
      '{CMD_STOP, 32'h0, 32'h0, 32'h0, 1'b0, 1'b0, CHK_MODEL},
      '{CMD_TICK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, CHK_NONE},
      '{CMD_STOP, 32'h0, 32'h0, 32'h0, 1'b1, 1'b0, CHK_MODEL}
    };
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    foreach (directed[i]) begin
      pace_sender();
      offer_request(directed[i]);
    end
    drain_results();
    for (int profile = 0; profile < PROFILES; profile++) begin
      load_profile(profile);
      bursty = (profile % 3 != 1);
      burst_left = 0;
      for (int n = 0; n < RANDOM_PER_PROFILE; n++) begin
        pace_sender();
        offer_request(random_request());
      end
      drain_results();
    end
    if (fault_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[mecanum_wheel_speed_mixer_top.f]
hdl/mwsm_pkg.sv
hdl/mecanum_wheel_speed_mixer_top.sv
verif/tb_mecanum_wheel_speed_mixer_top.sv
